FILE: hdl/okvt_pkg.sv
// Package for the ordered key/value table: beat structs, command and status codes,
// and the token that walks the row of cells during a search.
// Depends on nothing; every other file in hdl/ refers to it by scoped name.
package okvt_pkg;

   localparam int KEY_BITS   = 32;
   localparam int WORD_BITS  = 64;
   localparam int COUNT_BITS = 8;

   typedef logic [1:0] cmd_type;
   localparam cmd_type CMD_ADD    = 2'd0;
   localparam cmd_type CMD_FIND   = 2'd1;
   localparam cmd_type CMD_DELETE = 2'd2;
   localparam cmd_type CMD_CLEAR  = 2'd3;

   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK      = 2'd0;
   localparam status_type STATUS_FULL    = 2'd1;
   localparam status_type STATUS_MISSING = 2'd2;

   typedef struct packed {
      cmd_type                     cmd;
      logic signed [KEY_BITS-1:0]  key;
      logic [WORD_BITS-1:0]        payload;
   } req_type;

   typedef struct packed {
      status_type                  status;
      logic [WORD_BITS-1:0]        found_value;
      logic [COUNT_BITS-1:0]       entry_count;
   } rsp_type;

   // Search token handed from one cell to the next, one cell per cycle.
   typedef struct packed {
      logic                        active;
      logic                        hit;
      logic [WORD_BITS-1:0]        value;
   } token_type;

endpackage

FILE: hdl/ordered_key_value_table.sv
// Top level of the ordered key/value table: command sequencer, fill count,
// result register and the row of okvt_cell entries. Depends on okvt_pkg, okvt_cell.
//
// Usage: commands arrive as req_data beats on req_valid/req_ready, results leave as
// rsp_data beats on rsp_valid/rsp_ready, one result beat for every command beat.
// Add writes the entry at the tail cell in the cycle it is accepted, and clear only
// zeroes the fill count; both go to ST_DONE, which loads the output register.
// Find and delete launch a token into cell 0 that moves up one cell per cycle. Each
// cell compares its key against the broadcast key; the first match loads its value
// into the token, and on delete every cell at or above the match copies its upper
// neighbor as the token passes. The token is registered in tok_src_ff and in each
// cell on its way to the output of the last cell, after which the sequencer goes
// to ST_DONE to load the result.
// One command is in work at a time; a new command can be taken as soon as the
// previous result has moved into the output register, even while that result waits.
// When the receiver stalls, the finished result is held and no further command is
// accepted until the output register frees up.
// Reset empties the table; stored words are not cleared.
module ordered_key_value_table #(
   parameter int TABLE_DEPTH = 128,
   parameter int VALUE_BITS  = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  okvt_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output okvt_pkg::rsp_type    rsp_data
);

   localparam int CW = $clog2(TABLE_DEPTH+1);
   localparam logic [CW-1:0] FULL_LEVEL = CW'(TABLE_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type                     state_ff, state_in;
   logic [CW-1:0]                 fill_ff, fill_in;
   okvt_pkg::cmd_type             op_ff, op_in;
   logic [okvt_pkg::KEY_BITS-1:0] key_ff, key_in;
   okvt_pkg::token_type           tok_src_ff, tok_src_in;
   okvt_pkg::status_type          status_ff, status_in;
   logic [okvt_pkg::WORD_BITS-1:0] found_ff, found_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   okvt_pkg::rsp_type             rsp_ff, rsp_in;

   logic                          accept;
   logic                          add_we;
   logic [CW+7:0]                 count_ext;

   okvt_pkg::token_type           tok [TABLE_DEPTH+1];
   logic [okvt_pkg::KEY_BITS-1:0] cell_key [TABLE_DEPTH];
   logic [VALUE_BITS-1:0]         cell_value [TABLE_DEPTH];

   assign tok[0]    = tok_src_ff;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign count_ext = {8'b0, fill_ff};

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      tok_src_in   = '0;
      status_in    = status_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      add_we       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in     = req_data.cmd;
               key_in    = req_data.key;
               status_in = okvt_pkg::STATUS_OK;
               found_in  = '0;
               unique case (req_data.cmd) inside
                  okvt_pkg::CMD_ADD: begin
                     if (fill_ff < FULL_LEVEL) begin
                        add_we  = 1'b1;
                        fill_in = fill_ff + CW'(1);
                     end else begin
                        status_in = okvt_pkg::STATUS_FULL;
                     end
                     state_in = ST_DONE;
                  end
                  okvt_pkg::CMD_CLEAR: begin
                     fill_in  = '0;
                     state_in = ST_DONE;
                  end
                  okvt_pkg::CMD_FIND, okvt_pkg::CMD_DELETE: begin
                     tok_src_in.active = 1'b1;
                     state_in          = ST_SCAN;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN: begin
            if (tok[TABLE_DEPTH].active) begin
               if (tok[TABLE_DEPTH].hit) begin
                  status_in = okvt_pkg::STATUS_OK;
                  if (op_ff == okvt_pkg::CMD_FIND) begin
                     found_in = tok[TABLE_DEPTH].value;
                  end else begin
                     fill_in = fill_ff - CW'(1);
                  end
               end else begin
                  status_in = okvt_pkg::STATUS_MISSING;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = status_ff;
               rsp_in.found_value = found_ff;
               rsp_in.entry_count = count_ext[7:0];
               state_in           = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         fill_ff           <= '0;
         rsp_valid_ff      <= 1'b0;
         tok_src_ff.active <= 1'b0;
      end else begin
         state_ff          <= state_in;
         fill_ff           <= fill_in;
         rsp_valid_ff      <= rsp_valid_in;
         tok_src_ff.active <= tok_src_in.active;
      end
      tok_src_ff.hit   <= tok_src_in.hit;
      tok_src_ff.value <= tok_src_in.value;
      op_ff            <= op_in;
      key_ff           <= key_in;
      status_ff        <= status_in;
      found_ff         <= found_in;
      rsp_ff           <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      logic [okvt_pkg::KEY_BITS-1:0] upper_key;
      logic [VALUE_BITS-1:0]         upper_value;

      if (i == TABLE_DEPTH - 1) begin : g_top
         assign upper_key   = cell_key[i];
         assign upper_value = cell_value[i];
      end else begin : g_mid
         assign upper_key   = cell_key[i+1];
         assign upper_value = cell_value[i+1];
      end

      okvt_cell #(
         .TABLE_DEPTH (TABLE_DEPTH),
         .VALUE_BITS  (VALUE_BITS),
         .INDEX       (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .fill       (fill_ff),
         .add_we     (add_we),
         .add_key    (req_data.key),
         .add_value  (req_data.payload[VALUE_BITS-1:0]),
         .search_key (key_ff),
         .is_delete  (op_ff == okvt_pkg::CMD_DELETE),
         .token_in   (tok[i]),
         .token_out  (tok[i+1]),
         .next_key   (upper_key),
         .next_value (upper_value),
         .key_out    (cell_key[i]),
         .value_out  (cell_value[i])
      );
   end

endmodule

FILE: hdl/okvt_cell.sv
// One entry of the ordered key/value table: key and value registers plus one
// stage of the search token chain. Depends on okvt_pkg.
module okvt_cell #(
   parameter int TABLE_DEPTH = 128,
   parameter int VALUE_BITS  = 64,
   parameter int INDEX       = 0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [$clog2(TABLE_DEPTH+1)-1:0]    fill,
   input  logic                                add_we,
   input  logic [okvt_pkg::KEY_BITS-1:0]       add_key,
   input  logic [VALUE_BITS-1:0]               add_value,
   input  logic [okvt_pkg::KEY_BITS-1:0]       search_key,
   input  logic                                is_delete,
   input  okvt_pkg::token_type                 token_in,
   output okvt_pkg::token_type                 token_out,
   input  logic [okvt_pkg::KEY_BITS-1:0]       next_key,
   input  logic [VALUE_BITS-1:0]               next_value,
   output logic [okvt_pkg::KEY_BITS-1:0]       key_out,
   output logic [VALUE_BITS-1:0]               value_out
);

   localparam int CW = $clog2(TABLE_DEPTH+1);
   localparam logic [CW-1:0] MY_POS = CW'(INDEX);

   logic [okvt_pkg::KEY_BITS-1:0] key_ff;
   logic [VALUE_BITS-1:0]         value_ff;
   okvt_pkg::token_type           token_ff;
   okvt_pkg::token_type           token_in_next;
   logic                          valid;
   logic                          match;
   logic                          shift;

   assign valid = MY_POS < fill;
   assign match = token_in.active && valid && !token_in.hit && (key_ff == search_key);
   // On delete, the matching cell and every later cell take their upper neighbor.
   assign shift = token_in.active && is_delete && (token_in.hit || match);

   always_comb begin
      token_in_next.active = token_in.active;
      token_in_next.hit    = token_in.hit || match;
      token_in_next.value  = match ? okvt_pkg::WORD_BITS'(value_ff) : token_in.value;
   end

   always_ff @(posedge clock) begin
      if (add_we && (fill == MY_POS)) begin
         key_ff   <= add_key;
         value_ff <= add_value;
      end else if (shift) begin
         key_ff   <= next_key;
         value_ff <= next_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff.active <= 1'b0;
      end else begin
         token_ff.active <= token_in_next.active;
      end
      token_ff.hit   <= token_in_next.hit;
      token_ff.value <= token_in_next.value;
   end

   assign token_out = token_ff;
   assign key_out   = key_ff;
   assign value_out = value_ff;

endmodule

FILE: tb/tb_ordered_key_value_table.sv
// Self-checking testbench for ordered_key_value_table: a mirror of the table predicts
// every result beat, with random gaps and stalls on both valid/ready channels.
// Depends on okvt_pkg and the RTL under hdl/.
module tb_ordered_key_value_table;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH  = 128;
   localparam int VALUE_BITS   = 64;
   localparam int RANDOM_ITEMS = 900;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam logic [okvt_pkg::WORD_BITS-1:0] VALUE_MASK =
      {okvt_pkg::WORD_BITS{1'b1}} >> (okvt_pkg::WORD_BITS - VALUE_BITS);

   typedef struct {
      okvt_pkg::req_type beat;
      bit                drain;
      bit                calm;
   } stim_item_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   okvt_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   okvt_pkg::rsp_type rsp_data;

   stim_item_type                        pending[$];
   okvt_pkg::rsp_type                    awaited_results[$];
   logic signed [okvt_pkg::KEY_BITS-1:0] key_pool[$];

   // Mirror of the table contents, updated as each command beat is accepted.
   logic [okvt_pkg::KEY_BITS-1:0]  mirror_keys[TABLE_DEPTH];
   logic [okvt_pkg::WORD_BITS-1:0] mirror_values[TABLE_DEPTH];
   int mirror_fill = 0;
   int peak_fill = 0;

   int n_accepted = 0;
   int n_returned = 0;
   int error_count = 0;
   int cycle_count = 0;
   int gap_left = 0;
   int stall_left = 0;
   int rx_calm_left = 0;
   bit draining = 1'b0;
   int cmd_tally[4] = '{0, 0, 0, 0};
   int full_refusals = 0;
   int missed_lookups = 0;
   int random_count = 0;

   ordered_key_value_table #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Mostly short pauses, now and then a long one.
   function automatic int pick_pause();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 15);
      return $urandom_range(20, 60);
   endfunction

   function automatic int first_position(logic [okvt_pkg::KEY_BITS-1:0] k);
      for (int i = 0; i < mirror_fill; i++) begin
         if (mirror_keys[i] == k) return i;
      end
      return mirror_fill;
   endfunction

   function automatic okvt_pkg::rsp_type table_apply(okvt_pkg::req_type beat);
      okvt_pkg::rsp_type outcome;
      int                pos;
      outcome.status      = okvt_pkg::STATUS_OK;
      outcome.found_value = '0;
      case (beat.cmd)
         okvt_pkg::CMD_ADD: begin
            if (mirror_fill < TABLE_DEPTH) begin
               mirror_keys[mirror_fill]   = beat.key;
               mirror_values[mirror_fill] = beat.payload & VALUE_MASK;
               mirror_fill++;
            end else begin
               outcome.status = okvt_pkg::STATUS_FULL;
            end
         end
         okvt_pkg::CMD_FIND: begin
            pos = first_position(beat.key);
            if (pos < mirror_fill) outcome.found_value = mirror_values[pos] & VALUE_MASK;
            else outcome.status = okvt_pkg::STATUS_MISSING;
         end
         okvt_pkg::CMD_DELETE: begin
            pos = first_position(beat.key);
            if (pos < mirror_fill) begin
               for (int i = pos; i + 1 < mirror_fill; i++) begin
                  mirror_keys[i]   = mirror_keys[i + 1];
                  mirror_values[i] = mirror_values[i + 1];
               end
               mirror_fill--;
            end else begin
               outcome.status = okvt_pkg::STATUS_MISSING;
            end
         end
         default: mirror_fill = 0;
      endcase
      if (mirror_fill > peak_fill) peak_fill = mirror_fill;
      outcome.entry_count = okvt_pkg::COUNT_BITS'(mirror_fill);
      return outcome;
   endfunction

   task automatic queue_beat(okvt_pkg::cmd_type c, logic signed [okvt_pkg::KEY_BITS-1:0] k,
                             logic [okvt_pkg::WORD_BITS-1:0] v, bit drain, bit calm);
      stim_item_type item;
      item.beat.cmd     = c;
      item.beat.key     = k;
      item.beat.payload = v;
      item.drain        = drain;
      item.calm         = calm;
      pending.push_back(item);
      if (c == okvt_pkg::CMD_ADD) begin
         key_pool.push_back(k);
         if (key_pool.size() > 40) void'(key_pool.pop_front());
      end
   endtask

   // Keys mostly reuse earlier adds so that finds and deletes hit.
   function automatic logic signed [okvt_pkg::KEY_BITS-1:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65 && key_pool.size() != 0) return key_pool[$urandom_range(0, key_pool.size() - 1)];
      if (r < 85) return $signed(okvt_pkg::KEY_BITS'($urandom_range(0, 15))) - 8;
      return $urandom;
   endfunction

   function automatic logic [okvt_pkg::WORD_BITS-1:0] pick_value();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return {$urandom, $urandom};
   endfunction

   function automatic okvt_pkg::cmd_type pick_cmd(int mix);
      int r;
      r = $urandom_range(0, 99);
      case (mix)
         0: begin
            if (r < 70) return okvt_pkg::CMD_ADD;
            if (r < 85) return okvt_pkg::CMD_FIND;
            return okvt_pkg::CMD_DELETE;
         end
         1: begin
            if (r < 34) return okvt_pkg::CMD_ADD;
            if (r < 66) return okvt_pkg::CMD_FIND;
            if (r < 98) return okvt_pkg::CMD_DELETE;
            return okvt_pkg::CMD_CLEAR;
         end
         default: begin
            if (r < 20) return okvt_pkg::CMD_ADD;
            if (r < 45) return okvt_pkg::CMD_FIND;
            return okvt_pkg::CMD_DELETE;
         end
      endcase
   endfunction

   // Driver: presents pending beats, holds each until accepted, inserts gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
         gap_left  <= 0;
         draining  <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (gap_left != 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending.size() == 0) begin
            req_valid <= 1'b0;
         end else if (pending[0].drain && (!draining || n_accepted != n_returned)) begin
            // Hold off until the block has returned everything it owes.
            draining  <= 1'b1;
            req_valid <= 1'b0;
         end else begin
            req_data  <= pending[0].beat;
            req_valid <= 1'b1;
            draining  <= 1'b0;
            gap_left  <= pending[0].calm ? 0 : pick_pause();
            void'(pending.pop_front());
         end
      end
   end

   // Monitor: predicts on each command beat, checks each result beat.
   always @(posedge clock) begin : monitor
      okvt_pkg::rsp_type want;
      int                r;
      if (reset) begin
         rsp_ready    <= 1'b0;
         stall_left   <= 0;
         rx_calm_left <= 0;
      end else begin
         if (req_valid && req_ready) begin
            awaited_results.push_back(table_apply(req_data));
            cmd_tally[req_data.cmd]++;
            n_accepted <= n_accepted + 1;
         end
         if (rsp_valid && rsp_ready) begin
            n_returned <= n_returned + 1;
            if (awaited_results.size() == 0) begin
               $error("result beat with no command outstanding: %p", rsp_data);
               error_count++;
            end else begin
               want = awaited_results.pop_front();
               if (want.status == okvt_pkg::STATUS_FULL) full_refusals++;
               if (want.status == okvt_pkg::STATUS_MISSING) missed_lookups++;
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
                  error_count++;
               end
               if (rsp_data.found_value !== want.found_value) begin
                  $error("found_value: expected %h, actual %h",
                         want.found_value, rsp_data.found_value);
                  error_count++;
               end
               if (rsp_data.entry_count !== want.entry_count) begin
                  $error("entry_count: expected %0d, actual %0d",
                         want.entry_count, rsp_data.entry_count);
                  error_count++;
               end
            end
         end
         if (rx_calm_left != 0) begin
            rx_calm_left <= rx_calm_left - 1;
            rsp_ready    <= 1'b1;
         end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            r = $urandom_range(0, 99);
            if (r < 2) rx_calm_left <= $urandom_range(200, 1500);
            else if (r < 25) stall_left <= pick_pause() + 1;
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      int  mix;
      int  seg_len;
      int  adds_done;
      int  overflow_runs;
      bit  seg_calm;
      bit  seg_drain;
      overflow_runs = 0;

      // Directed: empty table, key and value extremes, duplicates, shifts, clear.
      queue_beat(okvt_pkg::CMD_FIND,   32'sd0,         '0,                      1'b0, 1'b0);
      queue_beat(okvt_pkg::CMD_DELETE, 32'sd5,         '0,                      1'b0, 1'b0);
      queue_beat(okvt_pkg::CMD_ADD,    32'sh8000_0000, '0,                      1'b0, 1'b0);
      queue_beat(okvt_pkg::CMD_ADD,    32'sh7fff_ffff, '1,                      1'b0, 1'b0);
      queue_beat(okvt_pkg::CMD_ADD,    32'sd0,         64'h0123_4567_89ab_cdef, 1'b0, 1'b0);
      queue_beat(okvt_pkg::CMD_ADD,    -32'sd1,        64'h8000_0000_0000_0000, 1'b0, 1'b0);
      queue_beat(okvt_pkg::CMD_ADD,    32'sd0,         64'hfedc_ba98_7654_3210, 1'b0, 1'b0);
      queue_beat(okvt_pkg::CMD_FIND,   32'sh8000_0000, '1,                      1'b0, 1'b0);
      queue_beat(okvt_pkg::CMD_FIND,   32'sh7fff_ffff, '0,                      1'b0, 1'b0);
      queue_beat(okvt_pkg::CMD_FIND,   32'sd0,         '0,                      1'b0, 1'b0);
      queue_beat(okvt_pkg::CMD_FIND,   32'sd12345,     '0,                      1'b0, 1'b0);
      queue_beat(okvt_pkg::CMD_DELETE, 32'sd0,         '0,                      1'b1, 1'b0);
      queue_beat(okvt_pkg::CMD_FIND,   32'sd0,         '0,                      1'b0, 1'b0);
      queue_beat(okvt_pkg::CMD_FIND,   -32'sd1,        '0,                      1'b0, 1'b0);
      queue_beat(okvt_pkg::CMD_DELETE, 32'sh8000_0000, '0,                      1'b0, 1'b0);
      queue_beat(okvt_pkg::CMD_DELETE, 32'sd99,        '0,                      1'b0, 1'b0);
      queue_beat(okvt_pkg::CMD_FIND,   32'sh7fff_ffff, '0,                      1'b0, 1'b0);
      queue_beat(okvt_pkg::CMD_CLEAR,  32'sd0,         '0,                      1'b0, 1'b0);
      queue_beat(okvt_pkg::CMD_FIND,   32'sh7fff_ffff, '0,                      1'b0, 1'b0);
      queue_beat(okvt_pkg::CMD_ADD,    32'sd7,         64'h5a5a_a5a5_0f0f_f0f0, 1'b0, 1'b0);
      queue_beat(okvt_pkg::CMD_FIND,   32'sd7,         '0,                      1'b0, 1'b0);
      queue_beat(okvt_pkg::CMD_DELETE, 32'sd7,         '0,                      1'b0, 1'b0);
      queue_beat(okvt_pkg::CMD_CLEAR,  32'sd0,         '0,                      1'b0, 1'b0);

      // Random segments; twice the table is filled past capacity from empty.
      while (random_count < RANDOM_ITEMS) begin
         seg_calm  = ($urandom_range(0, 4) == 0);
         seg_drain = ($urandom_range(0, 5) == 0);
         if ((overflow_runs == 0 && random_count >= 150) ||
             (overflow_runs == 1 && random_count >= 550)) begin
            overflow_runs++;
            queue_beat(okvt_pkg::CMD_CLEAR, pick_key(), pick_value(), 1'b1, seg_calm);
            random_count++;
            adds_done = 0;
            while (adds_done < TABLE_DEPTH + 12) begin
               if ($urandom_range(0, 7) == 0) begin
                  queue_beat(okvt_pkg::CMD_FIND, pick_key(), pick_value(), 1'b0, seg_calm);
               end else begin
                  queue_beat(okvt_pkg::CMD_ADD, $urandom, pick_value(), 1'b0, seg_calm);
                  adds_done++;
               end
               random_count++;
            end
         end else begin
            mix     = $urandom_range(0, 9);
            mix     = (mix < 4) ? 0 : (mix < 8) ? 1 : 2;
            seg_len = $urandom_range(15, 60);
            if ($urandom_range(0, 99) < 6) begin
               queue_beat(okvt_pkg::CMD_CLEAR, pick_key(), pick_value(), seg_drain, seg_calm);
               seg_drain = 1'b0;
               random_count++;
            end
            for (int i = 0; i < seg_len; i++) begin
               queue_beat(pick_cmd(mix), pick_key(), pick_value(), seg_drain && i == 0,
                          seg_calm);
               random_count++;
            end
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending.size() != 0 || req_valid) @(posedge clock);
      while (n_returned != n_accepted) @(posedge clock);
      repeat (TABLE_DEPTH + 10) @(posedge clock);
      if (awaited_results.size() != 0) begin
         $error("%0d results never arrived", awaited_results.size());
         error_count++;
      end

      $display("Ran %0d adds (%0d refused on a full table), %0d finds, %0d deletes, %0d clears;",
               cmd_tally[okvt_pkg::CMD_ADD], full_refusals, cmd_tally[okvt_pkg::CMD_FIND],
               cmd_tally[okvt_pkg::CMD_DELETE], cmd_tally[okvt_pkg::CMD_CLEAR]);
      $display("%0d lookups missed, table reached %0d entries, %0d cycles.",
               missed_lookups, peak_fill, cycle_count);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/okvt_pkg.sv
hdl/okvt_cell.sv
hdl/ordered_key_value_table.sv
tb/tb_ordered_key_value_table.sv
